// File: rtl/acio_pkg.sv
// types and constants shared by the arcade input and crash logic
// no dependencies; used by every module in rtl
package acio_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] CFG_DIP_A = 2'd0;
	localparam logic [1:0] CFG_DIP_B = 2'd1;
	localparam logic [1:0] CFG_DIP_C = 2'd2;

	localparam logic [7:0] DIP_A_RESET = 8'h90;
	localparam logic [7:0] DIP_B_RESET = 8'hA0;
	localparam logic [7:0] DIP_C_RESET = 8'h00;

	localparam logic [15:0] WIN_MASK  = 16'hFE00;
	localparam logic [15:0] WIN_INPUT = 16'h0600;
	localparam logic [15:0] WIN_PANEL = 16'h0800;
	localparam logic [15:0] WIN_CRASH = 16'h0C00;

	localparam logic [2:0] GEAR_MIN   = 3'd1;
	localparam logic [2:0] GEAR_MAX   = 3'd4;
	localparam logic [3:0] CRASH_FULL = 4'hF;
	localparam logic [6:0] PANEL_FLIP = 7'h0F;

	localparam logic [1:0] TRACK_NOVICE = 2'd0;
	localparam logic [1:0] TRACK_EXPERT = 2'd1;
	localparam logic [1:0] TRACK_PRO    = 2'd2;

	localparam logic [1:0] SEL_DIP_A = 2'd0;
	localparam logic [1:0] SEL_DIP_B = 2'd1;
	localparam logic [1:0] SEL_GEAR  = 2'd2;
	localparam logic [1:0] SEL_STEER = 2'd3;

	localparam logic [2:0] SEL_TRACK_EXPERT = 3'd4;
	localparam logic [2:0] SEL_TRACK_NOVICE = 3'd5;
	localparam logic [2:0] SEL_PHASE        = 3'd6;
	localparam logic [2:0] SEL_NONE         = 3'd7;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [6:0]  panel_buttons;
		logic [1:0]  gear_buttons;
		logic [1:0]  steer_buttons;
		logic        vblank;
	} item_t;

	typedef struct packed {
		logic [7:0] dip_a;
		logic [7:0] dip_b;
		logic [7:0] dip_c;
	} dips_t;

	function automatic logic [7:0] gear_code(input logic [2:0] gear);
		logic [7:0] code;
		unique case (gear)
			3'd1:    code = 8'hE0;
			3'd2:    code = 8'hD0;
			3'd3:    code = 8'hB0;
			3'd4:    code = 8'h70;
			default: code = 8'hE0;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/acio_in_stage.sv
// input register stage for bus requests and frame ticks
// depends on acio_pkg for the item type
module acio_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  acio_pkg::item_t item,
	input  logic           advance,
	output logic           valid_s1,
	output acio_pkg::item_t item_s1
);

	logic accept;

	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

// File: rtl/acio_datapath.sv
// board state, read decode and crash countdown with the result register
// depends on acio_pkg for types, codes and address windows
module acio_datapath #(
	parameter int CRASH_FRAME_DIVIDE = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  acio_pkg::item_t item_s1,
	input  acio_pkg::dips_t dips,
	output logic            advance,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      read_data,
	output logic            screen_invert,
	output logic [3:0]      crash_level
);

	localparam logic [2:0] DIVIDE = 3'(CRASH_FRAME_DIVIDE);

	logic [2:0] gear_q, gear_d;
	logic [1:0] prior_q, prior_d;
	logic [1:0] track_q, track_d;
	logic [1:0] phase_q, phase_d;
	logic       enable_q, enable_d;
	logic       armed_q, armed_d;
	logic [3:0] count_q, count_d;
	logic [2:0] div_q, div_d;
	logic       invert_q, invert_d;
	logic [7:0] rd_d;

	logic       out_valid_q;
	logic [7:0] rd_q;
	logic       invert_out_q;
	logic [3:0] level_q;

	logic [15:0] win;
	logic [1:0]  rise;
	logic [6:0]  port;
	logic [2:0]  div_inc;
	logic [3:0]  count_dec;
	logic [7:0]  steer;

	assign advance = valid_s1 & (~out_valid_q | ~out_stall);

	assign win       = item_s1.address & acio_pkg::WIN_MASK;
	assign rise      = item_s1.gear_buttons & ~prior_q;
	assign port      = item_s1.panel_buttons ^ acio_pkg::PANEL_FLIP;
	assign div_inc   = div_q + 3'd1;
	assign count_dec = count_q - 4'd1;
	assign steer     = item_s1.steer_buttons[0] ? 8'hC0 :
		(item_s1.steer_buttons[1] ? 8'h80 : 8'h00);

	always_comb begin
		gear_d   = gear_q;
		prior_d  = prior_q;
		track_d  = track_q;
		phase_d  = phase_q;
		enable_d = enable_q;
		armed_d  = armed_q;
		count_d  = count_q;
		div_d    = div_q;
		invert_d = invert_q;
		rd_d     = 8'h00;
		unique case (item_s1.command)
			acio_pkg::CMD_READ: begin
				if (win == acio_pkg::WIN_INPUT) begin
					prior_d = item_s1.gear_buttons;
					if (rise[0] && !rise[1] && gear_q != acio_pkg::GEAR_MAX) begin
						gear_d = gear_q + 3'd1;
					end else if (rise[1] && !rise[0] && gear_q != acio_pkg::GEAR_MIN) begin
						gear_d = gear_q - 3'd1;
					end
					unique case (item_s1.address[1:0])
						acio_pkg::SEL_DIP_A: rd_d = dips.dip_a;
						acio_pkg::SEL_DIP_B: rd_d = {dips.dip_b[7], item_s1.vblank,
							dips.dip_b[5:0]};
						acio_pkg::SEL_GEAR:  rd_d = acio_pkg::gear_code(gear_d);
						acio_pkg::SEL_STEER: rd_d = (dips.dip_c & 8'h20) | steer;
						default:             rd_d = 8'h00;
					endcase
				end else if (win == acio_pkg::WIN_PANEL) begin
					phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
					priority if (port[4]) begin
						track_d = acio_pkg::TRACK_NOVICE;
					end else if (port[5]) begin
						track_d = acio_pkg::TRACK_EXPERT;
					end else if (port[6]) begin
						track_d = acio_pkg::TRACK_PRO;
					end else begin
						track_d = track_q;
					end
					if (!item_s1.address[2]) begin
						rd_d = {port[item_s1.address[1:0]], 7'd0};
					end else begin
						unique case (item_s1.address[2:0])
							acio_pkg::SEL_TRACK_EXPERT:
								rd_d = {track_d == acio_pkg::TRACK_EXPERT, 7'd0};
							acio_pkg::SEL_TRACK_NOVICE:
								rd_d = {track_d == acio_pkg::TRACK_NOVICE, 7'd0};
							acio_pkg::SEL_PHASE:
								rd_d = {phase_d == 2'd0, 7'd0};
							acio_pkg::SEL_NONE:
								rd_d = 8'h00;
							default:
								rd_d = 8'h00;
						endcase
					end
				end
			end
			acio_pkg::CMD_WRITE: begin
				if (win == acio_pkg::WIN_CRASH) begin
					enable_d = item_s1.write_data[0];
					if (!item_s1.write_data[0]) begin
						armed_d  = 1'b1;
						count_d  = acio_pkg::CRASH_FULL;
						invert_d = 1'b1;
					end
				end
			end
			acio_pkg::CMD_TICK: begin
				if (div_inc == DIVIDE) begin
					div_d = 3'd0;
					if (enable_q && armed_q) begin
						count_d  = count_dec;
						armed_d  = (count_dec != 4'd0);
						invert_d = count_dec[0];
					end
				end else begin
					div_d = div_inc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q      <= acio_pkg::GEAR_MIN;
			prior_q     <= 2'd0;
			track_q     <= acio_pkg::TRACK_NOVICE;
			phase_q     <= 2'd0;
			enable_q    <= 1'b0;
			armed_q     <= 1'b0;
			count_q     <= 4'd0;
			div_q       <= 3'd0;
			invert_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				gear_q   <= gear_d;
				prior_q  <= prior_d;
				track_q  <= track_d;
				phase_q  <= phase_d;
				enable_q <= enable_d;
				armed_q  <= armed_d;
				count_q  <= count_d;
				div_q    <= div_d;
				invert_q <= invert_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q         <= rd_d;
			invert_out_q <= invert_d;
			level_q      <= armed_d ? count_d : 4'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = rd_q;
	assign screen_invert = invert_out_q;
	assign crash_level   = level_q;

endmodule

// File: rtl/arcade_input_and_crash_io_core.sv
// top level of the arcade input and crash logic: dip registers and stage wiring
// depends on acio_pkg, acio_in_stage and acio_datapath
//
// channel   handshake            payload
// in        in_valid / in_stall  command address write_data panel_buttons
//                                gear_buttons steer_buttons vblank
// out       out_valid/out_stall  read_data screen_invert crash_level
// cfg       cfg_valid/cfg_ready  cfg_index cfg_data
//
// one request per cycle while out_stall does not hold the result; each result passes
// through the input register, then the result register, before it is on the outputs;
// the single decode and update stage sets the rate
// arst_n clears all board state and loads the dip reset values
// a stalled output holds its result while one more request waits in the
// input register; cfg_ready is always high
module arcade_input_and_crash_io_core #(
	parameter int CRASH_FRAME_DIVIDE = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [6:0]  panel_buttons,
	input  logic [1:0]  gear_buttons,
	input  logic [1:0]  steer_buttons,
	input  logic        vblank,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        screen_invert,
	output logic [3:0]  crash_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	acio_pkg::dips_t dips_q;
	acio_pkg::item_t item;
	acio_pkg::item_t item_s1;
	logic            valid_s1;
	logic            advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dips_q.dip_a <= acio_pkg::DIP_A_RESET;
			dips_q.dip_b <= acio_pkg::DIP_B_RESET;
			dips_q.dip_c <= acio_pkg::DIP_C_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				acio_pkg::CFG_DIP_A: dips_q.dip_a <= cfg_data;
				acio_pkg::CFG_DIP_B: dips_q.dip_b <= cfg_data;
				acio_pkg::CFG_DIP_C: dips_q.dip_c <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		item.command       = command;
		item.address       = address;
		item.write_data    = write_data;
		item.panel_buttons = panel_buttons;
		item.gear_buttons  = gear_buttons;
		item.steer_buttons = steer_buttons;
		item.vblank        = vblank;
	end

	acio_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	acio_datapath #(
		.CRASH_FRAME_DIVIDE (CRASH_FRAME_DIVIDE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.dips          (dips_q),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.screen_invert (screen_invert),
		.crash_level   (crash_level)
	);

endmodule

// File: tb/sv/acio_checker.sv
// result checker for arcade_input_and_crash_io_core: watches the request, result and
// dip write channels, predicts each result and compares it with what the block returns
// depends on acio_pkg
module acio_checker #(
	parameter int CRASH_FRAME_DIVIDE = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [6:0]  panel_buttons,
	input  logic [1:0]  gear_buttons,
	input  logic [1:0]  steer_buttons,
	input  logic        vblank,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  read_data,
	input  logic        screen_invert,
	input  logic [3:0]  crash_level,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          failures,
	output int          outstanding,
	output int          results_checked
);
	import acio_pkg::*;

	typedef struct packed {
		logic [7:0] read_data;
		logic       screen_invert;
		logic [3:0] crash_level;
	} io_result_t;

	io_result_t result_fifo[$];
	dips_t      dips;
	logic [2:0] gear_q;
	logic [1:0] gear_btn_q;
	logic [1:0] track_q;
	logic [1:0] phase_q;
	logic       crash_en_q;
	logic       crash_armed_q;
	logic [3:0] crash_cnt_q;
	logic [2:0] frame_div_q;
	logic       invert_q;
	int         fail_n;
	int         checked_n;

	task automatic reset_model();
		dips.dip_a    = DIP_A_RESET;
		dips.dip_b    = DIP_B_RESET;
		dips.dip_c    = DIP_C_RESET;
		gear_q        = GEAR_MIN;
		gear_btn_q    = '0;
		track_q       = TRACK_NOVICE;
		phase_q       = '0;
		crash_en_q    = 1'b0;
		crash_armed_q = 1'b0;
		crash_cnt_q   = '0;
		frame_div_q   = '0;
		invert_q      = 1'b0;
	endtask

	function automatic logic [7:0] gear_pattern(input logic [2:0] g);
		case (g)
			3'd2:    return 8'hD0;
			3'd3:    return 8'hB0;
			3'd4:    return 8'h70;
			default: return 8'hE0;
		endcase
	endfunction

	task automatic read_input_window(input item_t req, output logic [7:0] rd);
		logic [1:0] rise;
		int         g;
		rise = req.gear_buttons & ~gear_btn_q;
		g = int'(gear_q);
		if (rise[0])
			g++;
		if (rise[1])
			g--;
		if (g < int'(GEAR_MIN))
			g = int'(GEAR_MIN);
		if (g > int'(GEAR_MAX))
			g = int'(GEAR_MAX);
		gear_q = g[2:0];
		gear_btn_q = req.gear_buttons;
		case (req.address[1:0])
			SEL_DIP_A: rd = dips.dip_a;
			SEL_DIP_B: rd = {dips.dip_b[7], req.vblank, dips.dip_b[5:0]};
			SEL_GEAR:  rd = gear_pattern(gear_q);
			default: begin
				rd = dips.dip_c & 8'h20;
				if (req.steer_buttons[0])
					rd[7:6] = 2'b11;
				else if (req.steer_buttons[1])
					rd[7:6] = 2'b10;
			end
		endcase
	endtask

	task automatic read_panel_window(input item_t req, output logic [7:0] rd);
		logic [6:0] port;
		port = req.panel_buttons ^ PANEL_FLIP;
		phase_q = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
		// lowest numbered track button wins, none keeps the track
		if (port[4])
			track_q = TRACK_NOVICE;
		else if (port[5])
			track_q = TRACK_EXPERT;
		else if (port[6])
			track_q = TRACK_PRO;
		rd = '0;
		case (req.address[2:0])
			SEL_TRACK_EXPERT: rd[7] = (track_q == TRACK_EXPERT);
			SEL_TRACK_NOVICE: rd[7] = (track_q == TRACK_NOVICE);
			SEL_PHASE:        rd[7] = (phase_q == 2'd0);
			SEL_NONE:         rd = '0;
			default:          rd[7] = port[req.address[1:0]];
		endcase
	endtask

	task automatic advance_frame();
		frame_div_q = frame_div_q + 3'd1;
		if (int'(frame_div_q) == CRASH_FRAME_DIVIDE) begin
			frame_div_q = '0;
			if (crash_en_q && crash_armed_q) begin
				crash_cnt_q = crash_cnt_q - 4'd1;
				if (crash_cnt_q == '0)
					crash_armed_q = 1'b0;
				invert_q = crash_cnt_q[0];
			end
		end
	endtask

	task automatic predict_request(input item_t req, output io_result_t res);
		logic [7:0] rd;
		rd = '0;
		case (req.command)
			CMD_READ: begin
				if ((req.address & WIN_MASK) == WIN_INPUT)
					read_input_window(req, rd);
				else if ((req.address & WIN_MASK) == WIN_PANEL)
					read_panel_window(req, rd);
			end
			CMD_WRITE: begin
				if ((req.address & WIN_MASK) == WIN_CRASH) begin
					crash_en_q = req.write_data[0];
					if (!req.write_data[0]) begin
						crash_armed_q = 1'b1;
						crash_cnt_q   = CRASH_FULL;
						invert_q      = 1'b1;
					end
				end
			end
			CMD_TICK: advance_frame();
			default: ;
		endcase
		res.read_data     = rd;
		res.screen_invert = invert_q;
		res.crash_level   = crash_armed_q ? crash_cnt_q : 4'd0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		io_result_t got;
		io_result_t want;
		item_t      req;
		if (!arst_n) begin
			reset_model();
			result_fifo.delete();
			fail_n = 0;
			checked_n = 0;
			failures <= 0;
			outstanding <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DIP_A: dips.dip_a = cfg_data;
					CFG_DIP_B: dips.dip_b = cfg_data;
					CFG_DIP_C: dips.dip_c = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {read_data, screen_invert, crash_level};
				if (result_fifo.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("unexpected result: read_data %h screen_invert %b crash_level %h",
							got.read_data, got.screen_invert, got.crash_level);
				end else begin
					want = result_fifo.pop_front();
					if (got !== want) begin
						fail_n++;
						if (fail_n <= 10)
							$display("mismatch at result %0d: read_data %h/%h screen_invert %b/%b %s%h/%h",
								checked_n, want.read_data, got.read_data, want.screen_invert,
								got.screen_invert, "crash_level ", want.crash_level, got.crash_level);
					end
					checked_n++;
				end
			end
			if (in_valid && !in_stall) begin
				req = {command, address, write_data, panel_buttons, gear_buttons,
					steer_buttons, vblank};
				predict_request(req, want);
				result_fifo.push_back(want);
			end
			failures <= fail_n;
			outstanding <= result_fifo.size();
			results_checked <= checked_n;
		end
	end

endmodule

// File: tb/sv/testbench.sv
// top of the arcade input and crash logic testbench: clock, reset, dip writes,
// request stimulus with random gaps and output stalls, and the verdict
// depends on acio_pkg, arcade_input_and_crash_io_core and acio_checker
module testbench;
	import acio_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [6:0]  panel_buttons;
	logic [1:0]  gear_buttons;
	logic [1:0]  steer_buttons;
	logic        vblank;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        screen_invert;
	logic [3:0]  crash_level;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int   failures;
	int   outstanding;
	int   results_checked;
	int   requests_sent;
	int   settings_used;
	int   stall_left;
	int   free_left;
	logic calm;

	arcade_input_and_crash_io_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.address       (address),
		.write_data    (write_data),
		.panel_buttons (panel_buttons),
		.gear_buttons  (gear_buttons),
		.steer_buttons (steer_buttons),
		.vblank        (vblank),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.screen_invert (screen_invert),
		.crash_level   (crash_level),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	acio_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.address         (address),
		.write_data      (write_data),
		.panel_buttons   (panel_buttons),
		.gear_buttons    (gear_buttons),
		.steer_buttons   (steer_buttons),
		.vblank          (vblank),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.screen_invert   (screen_invert),
		.crash_level     (crash_level),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.failures        (failures),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// output stall: short and long bursts, long free stretches while calm
	always @(posedge clk) begin
		int r;
		if (!arst_n) begin
			stall_left = 0;
			free_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
			r = $urandom_range(0, 99);
			if (calm)
				free_left = 32;
			else if (r < 50)
				free_left = $urandom_range(0, 6);
			else if (r < 85)
				stall_left = $urandom_range(1, 3);
			else if (r < 97)
				stall_left = $urandom_range(4, 12);
			else
				stall_left = $urandom_range(30, 80);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] window_offset();
		return 16'($urandom_range(0, 511));
	endfunction

	function automatic item_t mk(input logic [1:0] cmd, input logic [15:0] addr,
		input logic [7:0] wd, input logic [6:0] panel, input logic [1:0] gb,
		input logic [1:0] steer, input logic vb);
		item_t it;
		it.command       = cmd;
		it.address       = addr;
		it.write_data    = wd;
		it.panel_buttons = panel;
		it.gear_buttons  = gb;
		it.steer_buttons = steer;
		it.vblank        = vb;
		return it;
	endfunction

	function automatic item_t random_fields(input logic [1:0] cmd, input logic [15:0] addr);
		return mk(cmd, addr, 8'($urandom), 7'($urandom), 2'($urandom), 2'($urandom),
			1'($urandom));
	endfunction

	// called at a rising edge, returns at the edge that accepts the request
	task automatic issue(input item_t req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= req.command;
		address       <= req.address;
		write_data    <= req.write_data;
		panel_buttons <= req.panel_buttons;
		gear_buttons  <= req.gear_buttons;
		steer_buttons <= req.steer_buttons;
		vblank        <= req.vblank;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_dips(input dips_t d, input bit spare);
		int last;
		last = spare ? 3 : 2;
		for (int i = 0; i <= last; i++) begin
			cfg_valid <= 1'b1;
			case (i)
				0: begin
					cfg_index <= CFG_DIP_A;
					cfg_data  <= d.dip_a;
				end
				1: begin
					cfg_index <= CFG_DIP_B;
					cfg_data  <= d.dip_b;
				end
				2: begin
					cfg_index <= CFG_DIP_C;
					cfg_data  <= d.dip_c;
				end
				default: begin
					cfg_index <= CFG_SPARE;
					cfg_data  <= 8'($urandom);
				end
			endcase
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random(input int count);
		int    done;
		int    r;
		int    len;
		item_t req;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				issue(random_fields(CMD_READ, WIN_INPUT | window_offset()));
				done++;
			end else if (r < 50) begin
				issue(random_fields(CMD_READ, WIN_PANEL | window_offset()));
				done++;
			end else if (r < 58) begin
				issue(random_fields(CMD_WRITE, WIN_CRASH | window_offset()));
				done++;
			end else if (r < 68) begin
				// arm, enable, then mostly frame ticks so the countdown runs out
				req = random_fields(CMD_WRITE, WIN_CRASH | window_offset());
				req.write_data[0] = 1'b0;
				issue(req);
				req = random_fields(CMD_WRITE, WIN_CRASH | window_offset());
				req.write_data[0] = 1'b1;
				issue(req);
				len = $urandom_range(40, 150);
				if (done + len + 2 > count)
					len = (count - done > 3) ? count - done - 2 : 1;
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (r < 85)
						issue(random_fields(CMD_TICK, 16'($urandom)));
					else if (r < 93)
						issue(random_fields(CMD_READ, WIN_INPUT | window_offset()));
					else
						issue(random_fields(CMD_READ, WIN_PANEL | window_offset()));
				end
				done += len + 2;
			end else if (r < 85) begin
				len = $urandom_range(1, 10);
				repeat (len)
					issue(random_fields(CMD_TICK, 16'($urandom)));
				done += len;
			end else begin
				issue(random_fields(2'($urandom), 16'($urandom)));
				done++;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		command       = CMD_READ;
		address       = '0;
		write_data    = '0;
		panel_buttons = '0;
		gear_buttons  = '0;
		steer_buttons = '0;
		vblank        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_DIP_A;
		cfg_data      = '0;
		calm          = 1'b0;
		requests_sent = 0;
		settings_used = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// input window: dips, vblank, gear edges, steering priority
		issue(mk(CMD_READ, 16'h0600, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0601, 8'h00, 7'h00, 2'd0, 2'd0, 1'b1));
		issue(mk(CMD_READ, 16'h0602, 8'h00, 7'h00, 2'd3, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0603, 8'h00, 7'h00, 2'd3, 2'd3, 1'b0));
		issue(mk(CMD_READ, 16'h0607, 8'h00, 7'h00, 2'd0, 2'd2, 1'b0));
		issue(mk(CMD_READ, 16'h07FF, 8'h00, 7'h00, 2'd1, 2'd0, 1'b1));
		issue(mk(CMD_READ, 16'h0602, 8'h00, 7'h00, 2'd2, 2'd1, 1'b0));
		issue(mk(CMD_READ, 16'h0602, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		// panel window: port bits, several and no track buttons, phase
		issue(mk(CMD_READ, 16'h0800, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0801, 8'h00, 7'h7F, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0802, 8'h00, 7'h60, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0803, 8'h00, 7'h40, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0804, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0805, 8'h00, 7'h20, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h0806, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_READ, 16'h09FF, 8'h00, 7'h7F, 2'd0, 2'd0, 1'b0));
		// unmapped read, reserved command, unmapped write
		issue(mk(CMD_READ, 16'hFFFF, 8'hFF, 7'h7F, 2'd3, 2'd3, 1'b1));
		issue(mk(CMD_SPARE, WIN_CRASH, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_WRITE, 16'h0000, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		// arm, enable, one divided frame step
		issue(mk(CMD_WRITE, WIN_CRASH, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		issue(mk(CMD_WRITE, 16'h0DFF, 8'h01, 7'h00, 2'd0, 2'd0, 1'b0));
		repeat (7)
			issue(mk(CMD_TICK, 16'h0000, 8'h00, 7'h00, 2'd0, 2'd0, 1'b0));
		drain();

		load_dips('{8'h00, 8'h00, 8'h00}, 1'b1);
		run_random(140);
		drain();
		load_dips('{8'hFF, 8'hFF, 8'hFF}, 1'b0);
		run_random(140);
		drain();
		calm <= 1'b1;
		load_dips(dips_t'(24'($urandom)), 1'b0);
		run_random(140);
		drain();
		calm <= 1'b0;
		load_dips('{8'h55, 8'hAA, 8'h20}, 1'b1);
		run_random(140);
		drain();
		load_dips(dips_t'(24'($urandom)), 1'b0);
		run_random(140);
		drain();
		load_dips(dips_t'(24'($urandom)), 1'b0);
		run_random(140);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d requests (reads, crash writes, frame ticks, noise)",
			requests_sent);
		$display("under %0d dip settings; %0d results compared, %0d failures",
			settings_used, results_checked, failures);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#7000000;
		$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/acio_pkg.sv
rtl/acio_in_stage.sv
rtl/acio_datapath.sv
rtl/arcade_input_and_crash_io_core.sv
tb/sv/acio_checker.sv
tb/sv/testbench.sv
